/* hdl/tfrc_pkg.sv */
`timescale 1ns / 1ps
package tfrc_pkg;

  localparam int MAX_POINTS_DEF = 1024;

  // action codes on the input channel
  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_EVAL  = 2'd2;

  // required direction codes
  localparam logic [1:0] REQ_PLUS   = 2'd0;
  localparam logic [1:0] REQ_MINUS  = 2'd1;
  localparam logic [1:0] REQ_EITHER = 2'd2;

  // evaluation modes
  localparam logic MODE_CIRCLE = 1'b0;
  localparam logic MODE_HELIX  = 1'b1;

  // register index, taken from paddr bit 2
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_DIR  = 1'b1;

  // shared multiplier: A is cut into four 18-bit chunks
  localparam int MUL_A_W = 72;
  localparam int MUL_B_W = 36;
  localparam int MUL_P_W = 108;

  // square root unit
  localparam int SQ_IN_W   = 68;
  localparam int SQ_ROOT_W = 34;

  typedef enum logic [2:0] {
    K_CLEAR = 3'b001,
    K_LOAD  = 3'b010,
    K_EVAL  = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] pw;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [30:0] rad;
    logic [31:0] slope;
    logic [31:0] offset;
  } item_t;

endpackage

/* hdl/tfrc_mul.sv */
`timescale 1ns / 1ps
module tfrc_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [tfrc_pkg::MUL_A_W-1:0]      a,
  input  logic [tfrc_pkg::MUL_B_W-1:0]      b,
  output logic                              done,
  output logic [tfrc_pkg::MUL_P_W-1:0]      p
);

  localparam int CH = 18;

  logic [tfrc_pkg::MUL_A_W-1:0] a_r;
  logic [tfrc_pkg::MUL_B_W-1:0] b_r;
  logic [tfrc_pkg::MUL_P_W-1:0] p_r;
  logic [1:0]                   cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [CH+tfrc_pkg::MUL_B_W-1:0] pp;

  // top chunk first, shift the partial sum up by one chunk each step
  assign pp = a_r[tfrc_pkg::MUL_A_W-1 -: CH] * b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        p_r    <= '0;
        cnt_r  <= 2'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        p_r   <= {p_r[tfrc_pkg::MUL_P_W-CH-1:0], {CH{1'b0}}}
                 + {{(tfrc_pkg::MUL_P_W-CH-tfrc_pkg::MUL_B_W){1'b0}}, pp};
        a_r   <= {a_r[tfrc_pkg::MUL_A_W-CH-1:0], {CH{1'b0}}};
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

/* hdl/tfrc_sqrt.sv */
`timescale 1ns / 1ps
module tfrc_sqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [tfrc_pkg::SQ_IN_W-1:0]    v,
  output logic                            done,
  output logic [tfrc_pkg::SQ_ROOT_W-1:0]  root
);

  localparam int RW = tfrc_pkg::SQ_ROOT_W;
  localparam int MW = RW + 3;

  logic [tfrc_pkg::SQ_IN_W-1:0] v_r;
  logic [MW-1:0]                rem_r;
  logic [RW-1:0]                root_r;
  logic [5:0]                   cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [MW-1:0]                rem_sh;
  logic [MW-1:0]                trial;

  // one result bit per step, restoring form
  assign rem_sh = {rem_r[MW-3:0], v_r[tfrc_pkg::SQ_IN_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        v_r    <= v;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= 6'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[RW-2:0], 1'b0};
        end
        v_r   <= {v_r[tfrc_pkg::SQ_IN_W-3:0], 2'b00};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

/* hdl/tfrc_angle.sv */
`timescale 1ns / 1ps
module tfrc_angle (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] dx,
  input  logic signed [32:0] dy,
  output logic               done,
  output logic [17:0]        angle
);

  localparam int STEPS = 22;

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_NORM = 3'b010,
    A_ITER = 3'b100
  } astate_t;

  function automatic logic signed [25:0] atan_step(input logic [4:0] i);
    logic signed [25:0] t;
    case (i)
      5'd0:  t = 26'sd2097152;
      5'd1:  t = 26'sd1238021;
      5'd2:  t = 26'sd654136;
      5'd3:  t = 26'sd332050;
      5'd4:  t = 26'sd166669;
      5'd5:  t = 26'sd83416;
      5'd6:  t = 26'sd41718;
      5'd7:  t = 26'sd20860;
      5'd8:  t = 26'sd10430;
      5'd9:  t = 26'sd5215;
      5'd10: t = 26'sd2608;
      5'd11: t = 26'sd1304;
      5'd12: t = 26'sd652;
      5'd13: t = 26'sd326;
      5'd14: t = 26'sd163;
      5'd15: t = 26'sd81;
      5'd16: t = 26'sd41;
      5'd17: t = 26'sd20;
      5'd18: t = 26'sd10;
      5'd19: t = 26'sd5;
      5'd20: t = 26'sd3;
      5'd21: t = 26'sd1;
      default: t = 26'sd0;
    endcase
    return t;
  endfunction

  astate_t            state_r;
  logic signed [35:0] x_r, y_r;
  logic signed [25:0] z_r;
  logic [4:0]         i_r;
  logic               done_r;
  logic [17:0]        angle_r;

  logic signed [35:0] dx_e, dy_e, xs, ys, x_new, y_new;
  logic signed [25:0] z_new, z_rnd;
  logic [35:0]        ym;
  logic               small_c;

  assign dx_e = {{3{dx[32]}}, dx};
  assign dy_e = {{3{dy[32]}}, dy};
  assign xs   = x_r >>> i_r;
  assign ys   = y_r >>> i_r;
  assign ym   = y_r[35] ? 36'(-y_r) : 36'(y_r);
  // x is never negative once started
  assign small_c = (36'(x_r) < 36'h080000000) && (ym < 36'h080000000);

  always_comb begin
    if (!y_r[35]) begin
      x_new = x_r + ys;
      y_new = y_r - xs;
      z_new = z_r + atan_step(i_r);
    end else begin
      x_new = x_r - ys;
      y_new = y_r + xs;
      z_new = z_r - atan_step(i_r);
    end
  end

  assign z_rnd = z_new + 26'sd32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        A_IDLE: begin
          if (start) begin
            if (dx == 33'sd0 && dy == 33'sd0) begin
              angle_r <= 18'd0;
              done_r  <= 1'b1;
            end else begin
              // left half plane: flip and start at half a turn
              x_r     <= dx[32] ? -dx_e : dx_e;
              y_r     <= dx[32] ? -dy_e : dy_e;
              z_r     <= dx[32] ? 26'sd8388608 : 26'sd0;
              state_r <= A_NORM;
            end
          end
        end
        A_NORM: begin
          if (small_c) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            i_r     <= 5'd0;
            state_r <= A_ITER;
          end
        end
        A_ITER: begin
          x_r <= x_new;
          y_r <= y_new;
          z_r <= z_new;
          i_r <= i_r + 5'd1;
          if (i_r == 5'(STEPS - 1)) begin
            angle_r <= z_rnd[23:6];
            done_r  <= 1'b1;
            state_r <= A_IDLE;
          end
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

/* hdl/tfrc_front.sv */
`timescale 1ns / 1ps
module tfrc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_action,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic signed [31:0]  in_point_z,
  input  logic [15:0]         in_point_weight,
  input  logic signed [31:0]  in_center_x,
  input  logic signed [31:0]  in_center_y,
  input  logic [30:0]         in_radius,
  input  logic signed [31:0]  in_helix_slope,
  input  logic signed [31:0]  in_helix_offset,
  output logic                q_valid,
  output tfrc_pkg::item_t     q_item,
  input  logic                q_pop
);

  tfrc_pkg::item_t fifo_mem [2];
  tfrc_pkg::item_t item_c;
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            code_ok, push, pop;

  // classify; the unused code is taken and dropped
  always_comb begin
    code_ok = 1'b1;
    item_c  = '{kind: tfrc_pkg::K_CLEAR, px: in_point_x, py: in_point_y,
                pz: in_point_z, pw: in_point_weight, cx: in_center_x,
                cy: in_center_y, rad: in_radius, slope: in_helix_slope,
                offset: in_helix_offset};
    case (in_action)
      tfrc_pkg::ACT_CLEAR: item_c.kind = tfrc_pkg::K_CLEAR;
      tfrc_pkg::ACT_LOAD:  item_c.kind = tfrc_pkg::K_LOAD;
      tfrc_pkg::ACT_EVAL:  item_c.kind = tfrc_pkg::K_EVAL;
      default:             code_ok = 1'b0;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall && code_ok;
  assign pop      = q_pop && (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr_r] <= item_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = fifo_mem[rd_ptr_r];

endmodule

/* hdl/tfrc_back.sv */
`timescale 1ns / 1ps
module tfrc_back #(
  parameter int MAX_POINTS = tfrc_pkg::MAX_POINTS_DEF,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tfrc_pkg::item_t   q_item,
  output logic              q_pop,
  input  logic              mode,
  input  logic [1:0]        req,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_cost,
  output logic              out_rejected,
  output logic              out_direction,
  output logic [18:0]       out_reference_angle,
  output logic [CNT_W-1:0]  out_point_total
);

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic [31:0] TWO_PI_Q29 = 32'hC90FDAA2;
  localparam logic [19:0] HALF_TURN  = 20'd131072;
  localparam logic [19:0] FULL_TURN  = 20'd262144;
  localparam logic [19:0] LO_INIT    = 20'd524288;
  localparam int AW = tfrc_pkg::MUL_A_W;
  localparam int BW = tfrc_pkg::MUL_B_W;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_E1_RD  = 18'h00002,
    S_E1_ANG = 18'h00004,
    S_SPREAD = 18'h00008,
    S_E2_RD  = 18'h00010,
    S_E2_UPD = 18'h00020,
    S_DIR    = 18'h00040,
    S_P_RD   = 18'h00080,
    S_P_LD   = 18'h00100,
    S_P_SQX  = 18'h00200,
    S_P_SQY  = 18'h00400,
    S_P_SQRT = 18'h00800,
    S_P_RSQ  = 18'h01000,
    S_P_PHI  = 18'h02000,
    S_P_TERM = 18'h04000,
    S_P_DZSQ = 18'h08000,
    S_P_WMUL = 18'h10000,
    S_DONE   = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [31:0] x_mem [MAX_POINTS];
  logic signed [31:0] y_mem [MAX_POINTS];
  logic signed [31:0] z_mem [MAX_POINTS];
  logic [15:0]        w_mem [MAX_POINTS];
  logic [19:0]        a_mem [MAX_POINTS];
  logic signed [31:0] x_q, y_q, z_q;
  logic [15:0]        w_q;
  logic [19:0]        a_q;

  logic [CNT_W-1:0]   count_r, n_r;
  logic [IDX_W-1:0]   idx_r;
  logic [31:0]        cx_r, cy_r, slope_r, off_r;
  logic [30:0]        rad_r;
  logic [19:0]        lo_r, hi_r, a0_r, ref_r;
  logic               dir_r, acc_r, wait_r;
  logic [63:0]        cost_r;
  logic [68:0]        sum_r;
  logic [32:0]        mdx_r, mdy_r;
  logic [34:0]        mr_r, mdz_r;
  logic [51:0]        pm_r;
  logic               psign_r;

  logic               out_valid_r, out_rej_r, out_dir_r;
  logic [63:0]        out_cost_r;
  logic [18:0]        out_ref_r;
  logic [CNT_W-1:0]   out_tot_r;

  logic               ld_we, a_we, last_c, spread_c, dir_c, dir_eff, accept_c;
  logic [19:0]        a_new, a_adj, a_wd, a_cur;
  logic signed [32:0] dx_c, dy_c;
  logic               mul_start, mul_done, sq_start, sq_done, ang_start, ang_done;
  logic [AW-1:0]      mul_a;
  logic [BW-1:0]      mul_b;
  logic [tfrc_pkg::MUL_P_W-1:0] mul_p;
  logic [tfrc_pkg::SQ_ROOT_W-1:0] root;
  logic [17:0]        ang;
  logic               unit_done;
  logic signed [35:0] r_c;
  logic signed [20:0] phi_c;
  logic [20:0]        phi_mag;
  logic [31:0]        slope_mag;
  logic signed [29:0] term_c;
  logic signed [34:0] dz_c;
  logic [76:0]        wq_c;
  logic [64:0]        cost_sum;
  logic               out_free;

  // point stores: one write port, one registered read port
  assign ld_we = q_pop && (q_item.kind == tfrc_pkg::K_LOAD)
                 && (count_r < CNT_W'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (ld_we) begin
      x_mem[count_r[IDX_W-1:0]] <= q_item.px;
      y_mem[count_r[IDX_W-1:0]] <= q_item.py;
      z_mem[count_r[IDX_W-1:0]] <= q_item.pz;
      w_mem[count_r[IDX_W-1:0]] <= q_item.pw;
    end
    if (a_we) a_mem[idx_r] <= a_wd;
    x_q <= x_mem[idx_r];
    y_q <= y_mem[idx_r];
    z_q <= z_mem[idx_r];
    w_q <= w_mem[idx_r];
    a_q <= a_mem[idx_r];
  end

  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign dx_c   = $signed({x_q[31], x_q}) - $signed({cx_r[31], cx_r});
  assign dy_c   = $signed({y_q[31], y_q}) - $signed({cy_r[31], cy_r});
  assign a_new  = {2'b00, ang};
  assign a_adj  = (a_q < HALF_TURN) ? a_q + FULL_TURN : a_q;
  assign a_we   = ((state_r == S_E1_ANG) && ang_done) || (state_r == S_E2_UPD);
  assign a_wd   = (state_r == S_E1_ANG) ? a_new : a_adj;
  assign a_cur  = a_wd;
  assign last_c = (CNT_W'(CNT_W'(idx_r) + CNT_W'(1)) == n_r);
  assign spread_c = (hi_r - lo_r) > HALF_TURN;
  assign dir_c    = (hi_r - a0_r) > (a0_r - lo_r);
  assign dir_eff  = (n_r != '0) && dir_c;
  assign accept_c = (mode == tfrc_pkg::MODE_CIRCLE)
                    ? (req == tfrc_pkg::REQ_EITHER || req == {1'b0, dir_eff})
                    : (req == {1'b0, dir_eff});

  assign r_c       = $signed({2'b00, root}) - $signed({5'b00000, rad_r});
  assign phi_c     = $signed({1'b0, a_q}) - $signed({1'b0, ref_r});
  assign phi_mag   = phi_c[20] ? 21'(-phi_c) : 21'(phi_c);
  assign slope_mag = slope_r[31] ? 32'(-$signed(slope_r)) : slope_r;
  assign term_c    = psign_r ? -$signed({1'b0, mul_p[83:55]})
                             : $signed({1'b0, mul_p[83:55]});
  assign dz_c      = $signed({{3{z_q[31]}}, z_q}) - $signed({{5{term_c[29]}}, term_c})
                     - $signed({{3{off_r[31]}}, off_r});
  assign wq_c      = mul_p[84:8];
  assign cost_sum  = {1'b0, cost_r} + {1'b0, wq_c[63:0]};
  assign out_free  = !out_valid_r || !out_stall;
  assign unit_done = mul_done || sq_done || ang_done;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_P_SQX:  begin mul_a = AW'(mdx_r);   mul_b = BW'(mdx_r);      end
      S_P_SQY:  begin mul_a = AW'(mdy_r);   mul_b = BW'(mdy_r);      end
      S_P_RSQ:  begin mul_a = AW'(mr_r);    mul_b = BW'(mr_r);       end
      S_P_PHI:  begin mul_a = AW'(slope_mag); mul_b = BW'(phi_mag);  end
      S_P_TERM: begin mul_a = AW'(pm_r);    mul_b = BW'(TWO_PI_Q29); end
      S_P_DZSQ: begin mul_a = AW'(mdz_r);   mul_b = BW'(mdz_r);      end
      S_P_WMUL: begin mul_a = AW'(sum_r);   mul_b = BW'(w_q);        end
      default:  begin mul_a = '0;           mul_b = '0;              end
    endcase
  end

  assign mul_start = !wait_r && ((state_r == S_P_SQX) || (state_r == S_P_SQY)
                     || (state_r == S_P_RSQ) || (state_r == S_P_PHI)
                     || (state_r == S_P_TERM) || (state_r == S_P_DZSQ)
                     || (state_r == S_P_WMUL));
  assign sq_start  = !wait_r && (state_r == S_P_SQRT);
  assign ang_start = !wait_r && (state_r == S_E1_ANG);

  tfrc_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  tfrc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .v({2'b00, sum_r[65:0]}), .done(sq_done), .root(root)
  );

  tfrc_angle u_angle (
    .clk(clk), .rst_n(rst_n), .start(ang_start), .dx(dx_c), .dy(dy_c),
    .done(ang_done), .angle(ang)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_pop && q_item.kind == tfrc_pkg::K_EVAL)
          state_nxt = (count_r == '0) ? S_DIR : S_E1_RD;
      end
      S_E1_RD:  state_nxt = S_E1_ANG;
      S_E1_ANG: if (ang_done) state_nxt = last_c ? S_SPREAD : S_E1_RD;
      S_SPREAD: state_nxt = spread_c ? S_E2_RD : S_DIR;
      S_E2_RD:  state_nxt = S_E2_UPD;
      S_E2_UPD: state_nxt = last_c ? S_DIR : S_E2_RD;
      S_DIR:    state_nxt = (accept_c && n_r != '0) ? S_P_RD : S_DONE;
      S_P_RD:   state_nxt = S_P_LD;
      S_P_LD: begin
        if (w_q == 16'd0) state_nxt = last_c ? S_DONE : S_P_RD;
        else              state_nxt = S_P_SQX;
      end
      S_P_SQX:  if (mul_done) state_nxt = S_P_SQY;
      S_P_SQY:  if (mul_done) state_nxt = S_P_SQRT;
      S_P_SQRT: if (sq_done)  state_nxt = S_P_RSQ;
      S_P_RSQ: begin
        if (mul_done)
          state_nxt = (mode == tfrc_pkg::MODE_HELIX) ? S_P_PHI : S_P_WMUL;
      end
      S_P_PHI:  if (mul_done) state_nxt = S_P_TERM;
      S_P_TERM: if (mul_done) state_nxt = S_P_DZSQ;
      S_P_DZSQ: if (mul_done) state_nxt = S_P_WMUL;
      S_P_WMUL: if (mul_done) state_nxt = last_c ? S_DONE : S_P_RD;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // hold a unit busy flag from start to done
      if (mul_start || sq_start || ang_start) wait_r <= 1'b1;
      else if (unit_done)                     wait_r <= 1'b0;

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            case (q_item.kind)
              tfrc_pkg::K_CLEAR: count_r <= '0;
              tfrc_pkg::K_LOAD:  if (ld_we) count_r <= count_r + CNT_W'(1);
              tfrc_pkg::K_EVAL: begin
                cx_r    <= q_item.cx;
                cy_r    <= q_item.cy;
                rad_r   <= q_item.rad;
                slope_r <= q_item.slope;
                off_r   <= q_item.offset;
                n_r     <= count_r;
                idx_r   <= '0;
                lo_r    <= LO_INIT;
                hi_r    <= 20'd0;
                a0_r    <= 20'd0;
              end
              default: count_r <= count_r;
            endcase
          end
        end
        S_E1_ANG, S_E2_UPD: begin
          if (a_we) begin
            if (a_cur < lo_r) lo_r <= a_cur;
            if (a_cur > hi_r) hi_r <= a_cur;
            if (idx_r == '0)  a0_r <= a_cur;
            if (!last_c)      idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_SPREAD: begin
          if (spread_c) begin
            lo_r  <= LO_INIT;
            hi_r  <= 20'd0;
            idx_r <= '0;
          end
        end
        S_DIR: begin
          dir_r  <= dir_eff;
          ref_r  <= (n_r == '0) ? 20'd0 : (dir_c ? lo_r : hi_r);
          acc_r  <= accept_c;
          cost_r <= accept_c ? 64'd0 : {64{1'b1}};
          idx_r  <= '0;
        end
        S_P_LD: begin
          mdx_r <= dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
          mdy_r <= dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
          if (w_q == 16'd0 && !last_c) idx_r <= idx_r + IDX_W'(1);
        end
        S_P_SQX:  if (mul_done) sum_r <= mul_p[68:0];
        S_P_SQY:  if (mul_done) sum_r <= sum_r + mul_p[68:0];
        S_P_SQRT: if (sq_done)  mr_r  <= r_c[35] ? 35'(-r_c) : r_c[34:0];
        S_P_RSQ:  if (mul_done) sum_r <= mul_p[68:0];
        S_P_PHI: begin
          if (mul_done) begin
            pm_r    <= mul_p[51:0];
            psign_r <= slope_r[31] ^ phi_c[20];
          end
        end
        S_P_TERM: if (mul_done) mdz_r <= dz_c[34] ? 35'(-dz_c) : 35'(dz_c);
        S_P_DZSQ: if (mul_done) sum_r <= sum_r + mul_p[68:0];
        S_P_WMUL: begin
          if (mul_done) begin
            // saturate on a wide term or on carry out of the sum
            if ((wq_c[76:64] != '0) || cost_sum[64]) cost_r <= {64{1'b1}};
            else                                     cost_r <= cost_sum[63:0];
            if (!last_c) idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_cost_r  <= cost_r;
            out_rej_r   <= !acc_r;
            out_dir_r   <= dir_r;
            out_ref_r   <= ref_r[18:0];
            out_tot_r   <= n_r;
          end
        end
        default: wait_r <= wait_r;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cost            = out_cost_r;
  assign out_rejected        = out_rej_r;
  assign out_direction       = out_dir_r;
  assign out_reference_angle = out_ref_r;
  assign out_point_total     = out_tot_r;

endmodule

/* hdl/track_fit_residual_cost_core.sv */
`timescale 1ns / 1ps
// Clear and load requests retire one per cycle through a two-entry request queue while no evaluate runs.
// Evaluate of n points: time grows with n, more per point in helix than in circle mode, plus angles,
// set by the one-step-a-cycle CORDIC, the 34-step square root and the chunked shared multiplier.
// One evaluate runs at a time; loads queue behind it. Result registered, one per evaluate.
// Synchronous active-low reset: count zero, mode circle, required direction either.
// Point stores are not cleared on reset.
module track_fit_residual_cost_core #(
  parameter int MAX_POINTS = tfrc_pkg::MAX_POINTS_DEF,
  parameter int CNT_W      = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  // input requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic [15:0]        in_point_weight,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic [30:0]        in_radius,
  input  logic signed [31:0] in_helix_slope,
  input  logic signed [31:0] in_helix_offset,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic [63:0]        out_cost,
  output logic               out_rejected,
  output logic               out_direction,
  output logic [18:0]        out_reference_angle,
  output logic [CNT_W-1:0]   out_point_total,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic            mode_r;
  logic [1:0]      req_r;
  logic            q_valid, q_pop;
  tfrc_pkg::item_t q_item;
  logic            cfg_wr;

  // register file: bit 2 of the address selects the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tfrc_pkg::MODE_CIRCLE;
      req_r  <= tfrc_pkg::REQ_EITHER;
    end else if (cfg_wr) begin
      if (paddr[2] == tfrc_pkg::REG_DIR) req_r  <= pwdata[1:0];
      else                               mode_r <= pwdata[0];
    end
  end

  // low address bits are ignored on writes; reads return zero unless they are zero
  assign prdata = (paddr[2] == tfrc_pkg::REG_DIR && paddr[1:0] == 2'b00)
                  ? {30'd0, req_r}
                  : ((paddr[1:0] == 2'b00) ? {31'd0, mode_r} : 32'd0);

  // front: accept and classify requests, queue them
  tfrc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_point_weight(in_point_weight), .in_center_x(in_center_x),
    .in_center_y(in_center_y), .in_radius(in_radius),
    .in_helix_slope(in_helix_slope), .in_helix_offset(in_helix_offset),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  // back: point stores, three-pass evaluate sequencer, result register
  tfrc_back #(
    .MAX_POINTS(MAX_POINTS),
    .CNT_W(CNT_W)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .mode(mode_r), .req(req_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_cost(out_cost),
    .out_rejected(out_rejected), .out_direction(out_direction),
    .out_reference_angle(out_reference_angle), .out_point_total(out_point_total)
  );

  // a rejected result always carries a saturated cost
  a_rej_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_cost == {64{1'b1}})
    else $error("rejected result without saturated cost");

  // point total never exceeds the store depth
  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_point_total <= CNT_W'(MAX_POINTS))
    else $error("point total beyond store depth");

  // circle mode with either direction accepted never rejects
  a_either: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r == tfrc_pkg::MODE_CIRCLE && req_r == tfrc_pkg::REQ_EITHER
    |-> !out_rejected)
    else $error("rejected while any direction is accepted");

endmodule

/* tb/sv/track_fit_residual_cost_checker.sv */
`timescale 1ns / 1ps
module track_fit_residual_cost_checker
  import tfrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic [15:0]        in_point_weight,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic [30:0]        in_radius,
  input  logic signed [31:0] in_helix_slope,
  input  logic signed [31:0] in_helix_offset,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [63:0]        out_cost,
  input  logic               out_rejected,
  input  logic               out_direction,
  input  logic [18:0]        out_reference_angle,
  input  logic [10:0]        out_point_total,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  localparam int unsigned HALF_TURN = 131072;
  localparam int unsigned FULL_TURN = 262144;
  localparam logic [63:0] COST_SAT = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [63:0] cost;
    logic        rejected;
    logic        direction;
    logic [18:0] ref_angle;
    logic [10:0] total;
  } score_t;

  const longint arc_step[22] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  longint      pt_x[MAX_POINTS_DEF];
  longint      pt_y[MAX_POINTS_DEF];
  longint      pt_z[MAX_POINTS_DEF];
  int unsigned pt_w[MAX_POINTS_DEF];
  int unsigned pt_ang[MAX_POINTS_DEF];
  int unsigned n_points;
  logic        mode;
  logic [1:0]  need_dir;
  score_t      score_q[$];

  function automatic logic [127:0] mag(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic int unsigned turn_angle(longint dx, longint dy);
    longint x, y, z, xs, ys;
    logic [63:0] zu;
    int i;
    if (dx == 0 && dy == 0) return 0;
    x = dx; y = dy; z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = longint'(1) << 23;
    end
    while (mag(x) < 128'h8000_0000 && mag(y) < 128'h8000_0000) begin
      x = x * 2; y = y * 2;
    end
    for (i = 0; i < 22; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + arc_step[i];
      end else begin
        x = x - ys; y = y + xs; z = z - arc_step[i];
      end
    end
    zu = z + 32;
    return int'(zu[23:6]);
  endfunction

  function automatic longint unsigned root_of(logic [127:0] v);
    logic [127:0] c, root;
    int b;
    root = 0;
    for (b = 33; b >= 0; b--) begin
      c = root | (128'd1 << b);
      if (c * c <= v) root = c;
    end
    return root[63:0];
  endfunction

  function automatic longint helix_z(longint slope, longint phi);
    longint prod, m;
    logic [127:0] w;
    prod = slope * phi;
    w = mag(prod) * 128'hC90F_DAA2;
    m = longint'(w[118:55]);
    return (prod < 0) ? -m : m;
  endfunction

  // score the stored points against one trial circle or helix
  function automatic score_t score_trial(longint cx, longint cy, longint rad,
                                         longint slope, longint offs);
    score_t s;
    int unsigned lo, hi, ref_a, a;
    logic dir, ok;
    longint dx, dy, r, dz;
    logic [127:0] acc, p, sum;
    int i;
    lo = 0; hi = 0; ref_a = 0; dir = 0;
    if (n_points > 0) begin
      lo = FULL_TURN * 2;
      for (i = 0; i < n_points; i++) begin
        a = turn_angle(pt_x[i] - cx, pt_y[i] - cy);
        pt_ang[i] = a;
        if (a < lo) lo = a;
        if (a > hi) hi = a;
      end
      if (hi - lo > HALF_TURN) begin
        lo = FULL_TURN * 2; hi = 0;
        for (i = 0; i < n_points; i++) begin
          if (pt_ang[i] < HALF_TURN) pt_ang[i] += FULL_TURN;
          if (pt_ang[i] < lo) lo = pt_ang[i];
          if (pt_ang[i] > hi) hi = pt_ang[i];
        end
      end
      if (hi - pt_ang[0] > pt_ang[0] - lo) dir = 1;
      ref_a = dir ? lo : hi;
    end
    if (mode == MODE_CIRCLE) ok = (need_dir == REQ_EITHER) || (need_dir == {1'b0, dir});
    else ok = (need_dir == {1'b0, dir});
    acc = 0;
    if (!ok) begin
      acc = 128'(COST_SAT);
    end else begin
      for (i = 0; i < n_points; i++) begin
        if (pt_w[i] != 0) begin
          dx = pt_x[i] - cx;
          dy = pt_y[i] - cy;
          r = longint'(root_of(mag(dx) * mag(dx) + mag(dy) * mag(dy))) - rad;
          sum = mag(r) * mag(r);
          if (mode == MODE_HELIX) begin
            dz = pt_z[i] - helix_z(slope, longint'(pt_ang[i]) - longint'(ref_a)) - offs;
            sum = sum + mag(dz) * mag(dz);
          end
          p = (sum * 128'(pt_w[i])) >> 8;
          // saturate on wide product or carry out of the sum
          if (p[127:64] != 0 || acc + p > 128'(COST_SAT)) acc = 128'(COST_SAT);
          else acc = acc + p;
        end
      end
    end
    s.cost = acc[63:0];
    s.rejected = !ok;
    s.direction = dir;
    s.ref_angle = ref_a[18:0];
    s.total = n_points[10:0];
    return s;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    score_t want;
    if (!rst_n) begin
      n_points = 0;
      mode = MODE_CIRCLE;
      need_dir = REQ_EITHER;
      score_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (score_q.size() == 0) begin
          report("unexpected result", out_cost, 0);
        end else begin
          want = score_q.pop_front();
          if (out_cost !== want.cost) report("cost", out_cost, want.cost);
          if (out_rejected !== want.rejected) report("rejected", out_rejected, want.rejected);
          if (out_direction !== want.direction)
            report("direction", out_direction, want.direction);
          if (out_reference_angle !== want.ref_angle)
            report("reference angle", out_reference_angle, want.ref_angle);
          if (out_point_total !== want.total) report("point total", out_point_total, want.total);
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MODE) mode = pwdata[0];
        else need_dir = pwdata[1:0];
      end
      if (in_valid && !in_stall) begin
        case (in_action)
          ACT_CLEAR: n_points = 0;
          ACT_LOAD: begin
            if (n_points < MAX_POINTS_DEF) begin
              pt_x[n_points] = longint'(in_point_x);
              pt_y[n_points] = longint'(in_point_y);
              pt_z[n_points] = longint'(in_point_z);
              pt_w[n_points] = in_point_weight;
              n_points++;
            end
          end
          ACT_EVAL: score_q.push_back(score_trial(longint'(in_center_x), longint'(in_center_y),
                                                  longint'(in_radius), longint'(in_helix_slope),
                                                  longint'(in_helix_offset)));
          default: ;
        endcase
      end
    end
    pending = score_q.size();
  end

endmodule

/* tb/sv/track_fit_residual_cost_core_tb.sv */
`timescale 1ns / 1ps
module track_fit_residual_cost_core_tb;
  import tfrc_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         in_action = ACT_CLEAR;
  logic signed [31:0] in_point_x = 0;
  logic signed [31:0] in_point_y = 0;
  logic signed [31:0] in_point_z = 0;
  logic [15:0]        in_point_weight = 0;
  logic signed [31:0] in_center_x = 0;
  logic signed [31:0] in_center_y = 0;
  logic [30:0]        in_radius = 0;
  logic signed [31:0] in_helix_slope = 0;
  logic signed [31:0] in_helix_offset = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [63:0]        out_cost;
  logic               out_rejected;
  logic               out_direction;
  logic [18:0]        out_reference_angle;
  logic [10:0]        out_point_total;
  logic               psel = 0;
  logic               penable = 0;
  logic               pwrite = 0;
  logic [2:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;

  // next request fields, filled before each send
  logic [31:0] f_px, f_py, f_pz, f_cx, f_cy, f_slope, f_offs;
  logic [15:0] f_w;
  logic [30:0] f_rad;

  int     burst_left = 0;
  int     send_style = 0;
  int     stall_style = 0;
  logic   hold_go = 0;
  logic   hold_seen = 0;
  int     hold_cnt = 0;
  int     items_sent = 0;
  longint cycles = 0;

  always #10 clk = ~clk;

  track_fit_residual_cost_core uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_action, .in_point_x, .in_point_y, .in_point_z,
    .in_point_weight, .in_center_x, .in_center_y, .in_radius, .in_helix_slope,
    .in_helix_offset,
    .out_valid, .out_stall, .out_cost, .out_rejected, .out_direction,
    .out_reference_angle, .out_point_total,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  track_fit_residual_cost_checker chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_action, .in_point_x, .in_point_y, .in_point_z,
    .in_point_weight, .in_center_x, .in_center_y, .in_radius, .in_helix_slope,
    .in_helix_offset,
    .out_valid, .out_stall, .out_cost, .out_rejected, .out_direction,
    .out_reference_angle, .out_point_total,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  // give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side stall: own random pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_cnt <= 4000;
      out_stall <= 1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1;
    end else begin
      case (stall_style)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= $urandom_range(0, 1);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // randomize every field so that unused ones toggle too
  task automatic scramble();
    f_px = $urandom; f_py = $urandom; f_pz = $urandom; f_w = $urandom;
    f_cx = $urandom; f_cy = $urandom; f_rad = $urandom;
    f_slope = $urandom; f_offs = $urandom;
  endtask

  // offer one request; bursts with random gaps in between
  task automatic send(logic [1:0] act);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case (send_style)
        0: gap = 0;
        1: gap = $urandom_range(0, 3);
        default: gap = $urandom_range(0, 20);
      endcase
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_action <= act;
    in_point_x <= f_px; in_point_y <= f_py; in_point_z <= f_pz;
    in_point_weight <= f_w;
    in_center_x <= f_cx; in_center_y <= f_cy; in_radius <= f_rad;
    in_helix_slope <= f_slope; in_helix_offset <= f_offs;
    // stall only moves at the rising edge, so sample it halfway
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (act != 2'd3) items_sent++;
  endtask

  task automatic cfg_write(logic idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  // drain results, then let queued clears and loads retire
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // load n points on an arc, then evaluate, mostly near the true circle
  task automatic arc_set(int n, int evals);
    real gx, gy, rr, t0, span, t;
    int i, k;
    gx = $itor($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    gy = $itor($signed($urandom_range(0, 1 << 23)) - (1 << 22));
    rr = $itor($urandom_range(256, 1 << 22));
    t0 = $itor($urandom_range(0, 6283)) / 1000.0;
    span = $itor($urandom_range(50, 6200)) / 1000.0;
    if ($urandom_range(0, 1)) span = -span;
    if ($urandom_range(0, 7) != 0) begin
      scramble();
      send(ACT_CLEAR);
    end
    for (i = 0; i < n; i++) begin
      scramble();
      t = t0 + span * i / (n > 1 ? n - 1 : 1);
      f_px = $rtoi(gx + rr * $cos(t)) + $signed($urandom_range(0, 64)) - 32;
      f_py = $rtoi(gy + rr * $sin(t)) + $signed($urandom_range(0, 64)) - 32;
      f_pz = $signed($urandom_range(0, 1 << 16)) - (1 << 15);
      case ($urandom_range(0, 9))
        0: f_w = 16'd0;
        1: f_w = 16'hFFFF;
        2: ;
        default: f_w = $urandom_range(1, 1024);
      endcase
      // occasional wild point anywhere in the plane
      if ($urandom_range(0, 15) == 0) begin
        f_px = $urandom; f_py = $urandom;
      end
      send(ACT_LOAD);
    end
    for (k = 0; k < evals; k++) begin
      scramble();
      if ($urandom_range(0, 5) != 0) begin
        f_cx = $rtoi(gx) + $signed($urandom_range(0, 512)) - 256;
        f_cy = $rtoi(gy) + $signed($urandom_range(0, 512)) - 256;
        f_rad = $rtoi(rr) + $urandom_range(0, 512);
        f_slope = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
        f_offs = $signed($urandom_range(0, 1 << 12)) - (1 << 11);
      end
      send(ACT_EVAL);
    end
  endtask

  initial begin
    int ph, i;
    logic [1:0] dir_tbl[8];
    logic       mode_tbl[8];
    mode_tbl = '{MODE_CIRCLE, MODE_CIRCLE, MODE_CIRCLE, MODE_HELIX,
                 MODE_HELIX, MODE_HELIX, MODE_CIRCLE, MODE_HELIX};
    dir_tbl = '{REQ_EITHER, REQ_PLUS, REQ_MINUS, REQ_PLUS,
                REQ_MINUS, REQ_EITHER, 2'd3, 2'd3};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty store, extremes, zero vector, unused code
    scramble(); send(ACT_EVAL);
    cfg_write_phase: begin
      settle();
      cfg_write(REG_MODE, MODE_HELIX);
      cfg_write(REG_DIR, REQ_PLUS);
    end
    scramble(); send(ACT_EVAL);
    scramble(); f_px = 32'h8000_0000; f_py = 32'h7FFF_FFFF; f_pz = 32'h8000_0000;
    f_w = 16'hFFFF; send(ACT_LOAD);
    scramble(); f_px = 32'h7FFF_FFFF; f_py = 32'h8000_0000; f_pz = 32'h7FFF_FFFF;
    f_w = 16'h0000; send(ACT_LOAD);
    scramble(); f_px = 0; f_py = 0; f_pz = 0; f_w = 16'h0100; send(ACT_LOAD);
    scramble(); send(2'd3);
    scramble(); f_cx = 0; f_cy = 0; f_rad = 0; f_slope = 32'h7FFF_FFFF;
    f_offs = 32'h8000_0000; send(ACT_EVAL);
    scramble(); f_cx = 32'h8000_0000; f_cy = 32'h7FFF_FFFF; f_rad = 31'h7FFF_FFFF;
    f_slope = 32'h8000_0000; f_offs = 32'h7FFF_FFFF; send(ACT_EVAL);
    settle();
    cfg_write(REG_MODE, MODE_CIRCLE);
    cfg_write(REG_DIR, REQ_EITHER);
    scramble(); send(ACT_EVAL);
    scramble(); f_cx = 0; f_cy = 0; send(ACT_EVAL);
    scramble(); send(ACT_CLEAR);
    scramble(); send(ACT_EVAL);

    // hold off results while sets keep coming so the input backs up
    settle();
    hold_go <= ~hold_go;
    for (i = 0; i < 4; i++) arc_set(3, 2);
    settle();

    for (ph = 0; ph < 8; ph++) begin
      settle();
      cfg_write(REG_MODE, {31'd0, mode_tbl[ph]});
      cfg_write(REG_DIR, {30'd0, dir_tbl[ph]});
      send_style = ph % 3;
      stall_style = (ph + 1) % 4;
      // fill the store past capacity once, in circle mode
      if (ph == 0) begin
        scramble(); send(ACT_CLEAR);
        for (i = 0; i < MAX_POINTS_DEF + 3; i++) begin
          scramble();
          f_px = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
          f_py = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
          send(ACT_LOAD);
        end
        scramble(); f_cx = 0; f_cy = 0; f_rad = 31'd1 << 18; send(ACT_EVAL);
        scramble(); send(ACT_CLEAR);
      end
      while (items_sent < 1200 + 250 * (ph + 1)) begin
        if ($urandom_range(0, 19) == 0) arc_set($urandom_range(20, 40), 1);
        else arc_set($urandom_range(1, 7), $urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0) begin
          scramble(); send($urandom_range(0, 3));
        end
      end
    end

    settle();
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* sim.f */
hdl/tfrc_pkg.sv
hdl/tfrc_mul.sv
hdl/tfrc_sqrt.sv
hdl/tfrc_angle.sv
hdl/tfrc_front.sv
hdl/tfrc_back.sv
hdl/track_fit_residual_cost_core.sv
tb/sv/track_fit_residual_cost_checker.sv
tb/sv/track_fit_residual_cost_core_tb.sv
